// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks used across the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page frame allocator package
// Sizes, operation and status codes, and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bpfa_pkg;

   localparam int NUM_FRAMES = 4096;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = NUM_FRAMES / WORD_BITS;
   localparam int ADDR_W     = $clog2(MAP_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int POS_W      = BIT_W + 1;
   localparam int FRAME_W    = 12;
   localparam int LEN_W      = 13;
   localparam int ACT_W      = 3;
   localparam int STAT_W     = 2;
   localparam int TDATA_W    = 32;

   localparam logic [WORD_BITS-1:0] ALL_FREE     = 32'hFFFF_FFFF;
   localparam logic [LEN_W-1:0]     FRAME_CAP    = LEN_W'(NUM_FRAMES);
   localparam logic [LEN_W-1:0]     LIMIT_RESET  = 13'd4096;

   // Operation codes.
   localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
   localparam logic [ACT_W-1:0] ACT_FREE  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FORCE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_QUERY = 3'd3;
   localparam logic [ACT_W-1:0] ACT_COUNT = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_RUN = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;

   typedef enum logic [1:0] {
      RD_SCAN,
      RD_MARK,
      RD_QUERY
   } rd_src_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_MARK_SETUP,
      S_MARK_RD,
      S_MARK_WR,
      S_QUERY_RD,
      S_QUERY_CHK,
      S_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic       load_req;
      logic       scan_start;
      logic       scan_run;
      rd_src_type rd_src;
      logic       mark_setup;
      logic       mark_write;
      logic       mark_next;
      logic       query_capture;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             len_zero;
      logic             scan_found;
      logic             scan_done;
      logic             mark_empty;
      logic             mark_last;
      logic             rsp_free;
   } sts_type;

endpackage

// ===== rtl/bpfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences each request through scan, mark, query and result phases.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output bpfa_pkg::cmd_type cmd,
   input  bpfa_pkg::sts_type sts
);
   import bpfa_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            unique case (sts.action) inside
               ACT_ALLOC: begin
                  state_in = sts.len_zero ? S_RESULT : S_SCAN;
               end
               ACT_COUNT:           state_in = S_SCAN;
               ACT_FREE, ACT_FORCE: state_in = S_MARK_SETUP;
               ACT_QUERY:           state_in = S_QUERY_RD;
               default:             state_in = S_RESULT;
            endcase
         end
         S_SCAN: begin
            if (sts.scan_found) state_in = S_MARK_SETUP;
            else if (sts.scan_done) state_in = S_RESULT;
         end
         S_MARK_SETUP: state_in = S_MARK_RD;
         S_MARK_RD: begin
            state_in = sts.mark_empty ? S_RESULT : S_MARK_WR;
         end
         S_MARK_WR: begin
            state_in = sts.mark_last ? S_RESULT : S_MARK_RD;
         end
         S_QUERY_RD:  state_in = S_QUERY_CHK;
         S_QUERY_CHK: state_in = S_RESULT;
         S_RESULT: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_src = RD_SCAN;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         S_DISPATCH: begin
            cmd.scan_start = ((sts.action == ACT_ALLOC) && !sts.len_zero) ||
                             (sts.action == ACT_COUNT);
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            cmd.rd_src   = RD_SCAN;
         end
         S_MARK_SETUP: cmd.mark_setup = 1'b1;
         S_MARK_RD:    cmd.rd_src = RD_MARK;
         S_MARK_WR: begin
            cmd.mark_write = 1'b1;
            cmd.mark_next  = !sts.mark_last;
         end
         S_QUERY_RD:  cmd.rd_src = RD_QUERY;
         S_QUERY_CHK: cmd.query_capture = 1'b1;
         S_RESULT:    cmd.rsp_load = sts.rsp_free;
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/bpfa_dp.sv =====
// ----------------------------------------------------------------------------
// Allocator datapath
// Free bitmap memory, two-stage word scan, run marking, query and result
// register.
// ----------------------------------------------------------------------------
module bpfa_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bpfa_pkg::TDATA_W-1:0]   req_tdata,
   input  logic                           csr_we,
   input  logic [bpfa_pkg::LEN_W-1:0]     csr_wdata,
   input  bpfa_pkg::cmd_type              cmd,
   output bpfa_pkg::sts_type              sts,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bpfa_pkg::TDATA_W-1:0]   rsp_tdata
);
   import bpfa_pkg::*;

   localparam int LIMW_W = LEN_W - BIT_W;
   localparam int PAD_W  = TDATA_W - (STAT_W + FRAME_W + 1 + LEN_W);
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

   // Frame limit and latched request.
   logic [LEN_W-1:0]   lim_ff, lim_in;
   logic [ACT_W-1:0]   action_ff, action_in;
   logic [FRAME_W-1:0] page_ff, page_in;
   logic [LEN_W-1:0]   len_ff, len_in;

   // Bitmap memory; a word never written reads as all free.
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] word_valid_ff, word_valid_in;
   logic [WORD_BITS-1:0] rd_mem_ff;
   logic                 rd_vld_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0] rd_word;

   // Scan issue and pipeline.
   logic [ADDR_W-1:0]    scan_addr_ff, scan_addr_in;
   logic                 scan_issue_ff, scan_issue_in;
   logic                 rdv_ff, rdv_in;
   logic [ADDR_W-1:0]    rd_idx_ff;
   logic                 a_valid_ff, a_valid_in;
   logic [ADDR_W-1:0]    a_idx_ff;
   logic [POS_W-1:0]     a_lz_ff [WORD_BITS];
   logic [POS_W-1:0]     a_lz_in [WORD_BITS];
   logic [POS_W-1:0]     a_pop_ff, a_pop_in;
   logic [LEN_W-1:0]     run_ff, run_in;
   logic [LEN_W-1:0]     total_ff, total_in;
   logic                 found_ff, found_in;
   logic [FRAME_W-1:0]   found_start_ff, found_start_in;
   logic                 scan_done_ff, scan_done_in;

   // Marking.
   logic [LEN_W-1:0]     mark_lo_ff, mark_lo_in;
   logic [LEN_W-1:0]     mark_hi_ff, mark_hi_in;
   logic [ADDR_W-1:0]    mark_addr_ff, mark_addr_in;
   logic                 mark_empty_ff, mark_empty_in;
   logic [WORD_BITS-1:0] mark_word;
   logic [LEN_W-1:0]     hi_m1;

   // Query and result.
   logic                 qbit_ff, qbit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TDATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // Stage signals.
   logic [WORD_BITS-1:0] lim_mask;
   logic [LIMW_W-1:0]    lim_word;
   logic [LIMW_W-1:0]    idx_ext;
   logic [WORD_BITS-1:0] free_w;
   logic [WORD_BITS-1:0] used_w;
   logic [LEN_W-1:0]     run_len [WORD_BITS];
   logic [WORD_BITS-1:0] hit;
   logic                 hit_any;
   logic [BIT_W-1:0]     hit_pos;
   logic [LEN_W-1:0]     start_full;
   logic [LEN_W-1:0]     run_next;
   logic                 scan_go;

   assign rd_word = rd_vld_ff ? rd_mem_ff : ALL_FREE;

   // ---------------- configuration and request capture ----------------
   always_comb begin
      lim_in = lim_ff;
      if (csr_we) begin
         lim_in = (csr_wdata > FRAME_CAP) ? FRAME_CAP : csr_wdata;
      end
      action_in = action_ff;
      page_in   = page_ff;
      len_in    = len_ff;
      if (cmd.load_req) begin
         action_in = req_tdata[ACT_W-1:0];
         page_in   = req_tdata[ACT_W +: FRAME_W];
         len_in    = req_tdata[ACT_W+FRAME_W +: LEN_W];
      end
   end

   // ---------------- memory ----------------
   always_comb begin
      unique case (cmd.rd_src)
         RD_SCAN:  rd_addr = scan_addr_ff;
         RD_MARK:  rd_addr = mark_addr_ff;
         RD_QUERY: rd_addr = page_ff[FRAME_W-1:BIT_W];
         default:  rd_addr = scan_addr_ff;
      endcase
      word_valid_in = word_valid_ff;
      if (cmd.mark_write) word_valid_in[mark_addr_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.mark_write) map_mem[mark_addr_ff] <= mark_word;
      rd_mem_ff <= map_mem[rd_addr];
   end

   // ---------------- scan stage A: limit mask, zero positions, popcount ----
   always_comb begin
      logic [POS_W-1:0] lvl [BIT_W+1][WORD_BITS];
      logic [POS_W-1:0] pa;
      logic [POS_W-1:0] pb;
      int               s;
      int               src;

      lim_word = lim_ff[LEN_W-1:BIT_W];
      idx_ext  = LIMW_W'(rd_idx_ff);
      if (lim_word > idx_ext) begin
         lim_mask = ALL_FREE;
      end else if (lim_word == idx_ext) begin
         lim_mask = ~(ALL_FREE << lim_ff[BIT_W-1:0]);
      end else begin
         lim_mask = '0;
      end
      // Frames at or above the limit look used to the scan.
      free_w = rd_word & lim_mask;
      used_w = ~rd_word & lim_mask;

      // Each lane holds one plus the position of the last used frame at or
      // below it, or zero when it and all lower frames in the word are free.
      for (int j = 0; j < WORD_BITS; j++) begin
         lvl[0][j] = free_w[j] ? '0 : POS_W'(j + 1);
      end
      for (int k = 0; k < BIT_W; k++) begin
         s = 1 << k;
         for (int j = 0; j < WORD_BITS; j++) begin
            src = (j >= s) ? (j - s) : j;
            pa  = lvl[k][j];
            pb  = lvl[k][src];
            lvl[k+1][j] = (pb > pa) ? pb : pa;
         end
      end
      for (int j = 0; j < WORD_BITS; j++) begin
         a_lz_in[j] = lvl[BIT_W][j];
      end

      a_pop_in = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         a_pop_in = a_pop_in + POS_W'(used_w[j]);
      end
   end

   // ---------------- scan stage B: run detection and totals ----------------
   always_comb begin
      logic [FRAME_W-1:0] end_frame;

      for (int j = 0; j < WORD_BITS; j++) begin
         if (a_lz_ff[j] == '0) begin
            run_len[j] = run_ff + LEN_W'(j + 1);
         end else begin
            run_len[j] = LEN_W'(j + 1) - LEN_W'(a_lz_ff[j]);
         end
         hit[j] = (run_len[j] >= len_ff);
      end
      hit_any = 1'b0;
      hit_pos = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (hit[j]) begin
            hit_any = 1'b1;
            hit_pos = BIT_W'(j);
         end
      end
      end_frame  = {a_idx_ff, hit_pos};
      start_full = LEN_W'(end_frame) + LEN_W'(1) - len_ff;

      if (a_lz_ff[WORD_BITS-1] == '0) begin
         run_next = run_ff + LEN_W'(WORD_BITS);
      end else begin
         run_next = LEN_W'(WORD_BITS) - LEN_W'(a_lz_ff[WORD_BITS-1]);
      end

      scan_go = a_valid_ff && !found_ff && !scan_done_ff;

      scan_addr_in  = scan_addr_ff;
      scan_issue_in = scan_issue_ff;
      if (cmd.scan_start) begin
         scan_addr_in  = '0;
         scan_issue_in = 1'b1;
      end else if (cmd.scan_run && scan_issue_ff) begin
         scan_addr_in = scan_addr_ff + ADDR_W'(1);
         if (scan_addr_ff == LAST_WORD) scan_issue_in = 1'b0;
      end
      rdv_in     = cmd.scan_run && scan_issue_ff;
      a_valid_in = cmd.scan_start ? 1'b0 : rdv_ff;

      run_in         = run_ff;
      total_in       = total_ff;
      found_in       = found_ff;
      found_start_in = found_start_ff;
      scan_done_in   = scan_done_ff;
      if (cmd.scan_start || cmd.load_req) begin
         run_in       = '0;
         total_in     = '0;
         found_in     = 1'b0;
         scan_done_in = 1'b0;
      end else if (scan_go) begin
         run_in   = run_next;
         total_in = total_ff + LEN_W'(a_pop_ff);
         if ((action_ff == ACT_ALLOC) && hit_any) begin
            found_in       = 1'b1;
            found_start_in = start_full[FRAME_W-1:0];
         end
         if (a_idx_ff == LAST_WORD) scan_done_in = 1'b1;
      end
   end

   // ---------------- run marking ----------------
   always_comb begin
      logic [FRAME_W-1:0] lo_sel;
      logic [LEN_W:0]     sum;
      logic [LEN_W-1:0]   g;
      logic [WORD_BITS-1:0] m;

      lo_sel = (action_ff == ACT_ALLOC) ? found_start_ff : page_ff;
      // One extra bit so that a long run from a high frame cannot wrap.
      sum    = (LEN_W+1)'(lo_sel) + (LEN_W+1)'(len_ff);

      mark_lo_in    = mark_lo_ff;
      mark_hi_in    = mark_hi_ff;
      mark_addr_in  = mark_addr_ff;
      mark_empty_in = mark_empty_ff;
      if (cmd.mark_setup) begin
         mark_lo_in    = LEN_W'(lo_sel);
         mark_hi_in    = (sum > {1'b0, lim_ff}) ? lim_ff : sum[LEN_W-1:0];
         mark_addr_in  = lo_sel[FRAME_W-1:BIT_W];
         mark_empty_in = (len_ff == '0) || (LEN_W'(lo_sel) >= lim_ff);
      end else if (cmd.mark_next) begin
         mark_addr_in = mark_addr_ff + ADDR_W'(1);
      end

      for (int j = 0; j < WORD_BITS; j++) begin
         g    = LEN_W'({mark_addr_ff, BIT_W'(j)});
         m[j] = (g >= mark_lo_ff) && (g < mark_hi_ff);
      end
      mark_word = (action_ff == ACT_FREE) ? (rd_word | m) : (rd_word & ~m);
   end

   assign hi_m1 = mark_hi_ff - LEN_W'(1);

   // ---------------- query and result ----------------
   always_comb begin
      logic [STAT_W-1:0]  r_status;
      logic [FRAME_W-1:0] r_start;
      logic               r_used;
      logic [LEN_W-1:0]   r_total;

      qbit_in = qbit_ff;
      if (cmd.query_capture) qbit_in = ~rd_word[page_ff[BIT_W-1:0]];

      r_status = ST_OK;
      r_start  = '0;
      r_used   = 1'b0;
      r_total  = '0;
      unique case (action_ff)
         ACT_ALLOC: begin
            if (found_ff) r_start = found_start_ff;
            else r_status = ST_NO_RUN;
         end
         ACT_QUERY: begin
            if (LEN_W'(page_ff) >= lim_ff) r_status = ST_RANGE;
            else r_used = qbit_ff;
         end
         ACT_COUNT: r_total = total_ff;
         default: begin
         end
      endcase
      // The response word stays put while it waits for the receiver.
      rsp_data_in = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_data_in = {{PAD_W{1'b0}}, r_total, r_used, r_start, r_status};
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff        <= LIMIT_RESET;
         word_valid_ff <= '0;
         scan_issue_ff <= 1'b0;
         rdv_ff        <= 1'b0;
         a_valid_ff    <= 1'b0;
         found_ff      <= 1'b0;
         scan_done_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         lim_ff        <= lim_in;
         word_valid_ff <= word_valid_in;
         scan_issue_ff <= scan_issue_in;
         rdv_ff        <= rdv_in;
         a_valid_ff    <= a_valid_in;
         found_ff      <= found_in;
         scan_done_ff  <= scan_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      page_ff        <= page_in;
      len_ff         <= len_in;
      rd_vld_ff      <= word_valid_ff[rd_addr];
      rd_idx_ff      <= scan_addr_ff;
      scan_addr_ff   <= scan_addr_in;
      a_idx_ff       <= rd_idx_ff;
      a_lz_ff        <= a_lz_in;
      a_pop_ff       <= a_pop_in;
      run_ff         <= run_in;
      total_ff       <= total_in;
      found_start_ff <= found_start_in;
      mark_lo_ff     <= mark_lo_in;
      mark_hi_ff     <= mark_hi_in;
      mark_addr_ff   <= mark_addr_in;
      mark_empty_ff  <= mark_empty_in;
      qbit_ff        <= qbit_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // ---------------- status to controller and outputs ----------------
   always_comb begin
      sts.action     = action_ff;
      sts.len_zero   = (len_ff == '0);
      sts.scan_found = found_ff;
      sts.scan_done  = scan_done_ff;
      sts.mark_empty = mark_empty_ff;
      sts.mark_last  = (mark_addr_ff == hi_m1[BIT_W +: ADDR_W]);
      sts.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/bitmap_page_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap page frame allocator
// One free bit per page frame; first-fit run allocation, free, force
// allocate, query and used-frame count.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req_ stream, one word per operation, and each
// produces exactly one response word on the rsp_ stream, in order. The frame
// limit is written via csr_we/csr_wdata, by the user only while the block is
// idle, not enforced by the block; values above the frame capacity are clamped.
// Timing: the bitmap lives in a 128 x 32 memory with one read and one write
// port. Allocate and count sweep it one word per cycle through a two-stage
// scan pipeline; an allocate that finds a run stops early and then marks it,
// reading and then writing each touched word. Free and force allocate also
// read and then write each touched word; an empty run, or one that starts at
// or above the limit, writes no word. Query reads the word, then checks it.
// One operation is in progress at a time; the next request is taken as soon
// as the controller returns to idle, even while a response still waits in the
// output register. If the receiver stalls, the next result holds until that
// register drains.
// Reset: all frames read as free (per-word valid bits), limit returns to 4096,
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_page_frame_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // action[2:0], page_number[14:3], frame_count[27:15], zero pad[31:28]
   input  logic [bpfa_pkg::TDATA_W-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // status[1:0], start_frame[13:2], frame_used[14], used_total[27:15],
   // zero pad[31:28]
   output logic [bpfa_pkg::TDATA_W-1:0] rsp_tdata,
   input  logic                         csr_we,
   input  logic [bpfa_pkg::LEN_W-1:0]   csr_wdata
);
   import bpfa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bpfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   bpfa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted but controller stayed ready")
   `ASSERT_IMPLIES(a_rsp_slot_free, clock, reset, cmd.rsp_load, !rsp_tvalid || rsp_tready, "result loaded over a pending response")
   `ASSERT_IMPLIES(a_found_only_alloc, clock, reset, sts.scan_found, sts.action == ACT_ALLOC, "run found outside an allocate")

endmodule

// ===== verif/tb_bitmap_page_frame_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page frame allocator testbench
// Drives allocate, free, force, query and count requests into the allocator
// under random stalls on both streams. It keeps its own copy of the frame
// bitmap and limit, and checks every response word field by field.
// ----------------------------------------------------------------------------
module tb_bitmap_page_frame_allocator;
   import bpfa_pkg::*;

   localparam logic [ACT_W-1:0] ACT_RSVD_FIRST = 3'd5;
   localparam logic [ACT_W-1:0] ACT_RSVD_LAST  = 3'd7;
   localparam logic [LEN_W-1:0] LEN_ALL_ONES   = '1;
   localparam int PAD_W = TDATA_W - ACT_W - FRAME_W - LEN_W;
   localparam int MAX_LINES = 50;

   // Response word layout, lowest bits last in the list.
   typedef struct packed {
      logic [LEN_W-1:0]   used_total;
      logic               frame_used;
      logic [FRAME_W-1:0] start_frame;
      logic [STAT_W-1:0]  status;
   } frame_result_type;

   localparam int RSP_BITS = $bits(frame_result_type);

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [TDATA_W-1:0]   req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [TDATA_W-1:0]   rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [LEN_W-1:0]     csr_wdata = '0;

   // Shadow of the allocator state.
   logic [WORD_BITS-1:0] free_bits [MAP_WORDS];
   logic [LEN_W-1:0]     limit_shadow;

   frame_result_type     pending_results [$];
   frame_result_type     oldest_result;
   frame_result_type     observed_result;
   int unsigned          mismatch_count = 0;
   bit                   quiet_mode = 1'b0;

   bitmap_page_frame_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #60_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_LINES) begin
         $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Frame bitmap predictor
   // ------------------------------------------------------------------------
   function automatic int unsigned managed_frames();
      return (limit_shadow > FRAME_CAP) ? NUM_FRAMES : int'(limit_shadow);
   endfunction

   function automatic bit frame_is_free(input int unsigned f);
      return free_bits[f / WORD_BITS][f % WORD_BITS];
   endfunction

   function automatic void mark_frames(input int unsigned start, input int unsigned len,
                                       input bit free_bit);
      int unsigned lim;
      int unsigned f;
      lim = managed_frames();
      for (int unsigned i = 0; i < len; i++) begin
         f = start + i;
         if (f >= lim) break;
         free_bits[f / WORD_BITS][f % WORD_BITS] = free_bit;
      end
   endfunction

   function automatic frame_result_type predict_frame_op(input logic [ACT_W-1:0] act,
                                                         input logic [FRAME_W-1:0] page,
                                                         input logic [LEN_W-1:0] len);
      frame_result_type res;
      int unsigned      lim;
      int unsigned      run;
      int unsigned      first_free;
      bit               found;
      res = '0;
      lim = managed_frames();
      run = 0;
      first_free = 0;
      found = 1'b0;
      case (act)
         ACT_ALLOC: begin
            if (len != 0) begin
               for (int unsigned f = 0; f < lim && !found; f++) begin
                  if (frame_is_free(f)) begin
                     if (run == 0) first_free = f;
                     run++;
                     if (run == len) found = 1'b1;
                  end else begin
                     run = 0;
                  end
               end
            end
            if (found) begin
               mark_frames(first_free, len, 1'b0);
               res.start_frame = FRAME_W'(first_free);
            end else begin
               res.status = ST_NO_RUN;
            end
         end
         ACT_FREE:  mark_frames(page, len, 1'b1);
         ACT_FORCE: mark_frames(page, len, 1'b0);
         ACT_QUERY: begin
            if (page >= lim) res.status = ST_RANGE;
            else res.frame_used = !frame_is_free(page);
         end
         ACT_COUNT: begin
            for (int unsigned f = 0; f < lim; f++) begin
               if (!frame_is_free(f)) res.used_total = res.used_total + 1'b1;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stream drivers
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= quiet_mode || ($urandom_range(99) >= 19);
   end

   task automatic send_request(input logic [ACT_W-1:0] act, input logic [FRAME_W-1:0] page,
                               input logic [LEN_W-1:0] len);
      while (!quiet_mode && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD_W{1'b0}}, len, page, act};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_frame_op(act, page, len));
   endtask

   // Always waits on the clock before it checks the queue, so the caller may drive freely afterward.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_limit(input logic [LEN_W-1:0] value);
      wait_for_drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_shadow = value;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed_result = frame_result_type'(rsp_tdata[RSP_BITS-1:0]);
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response word", rsp_tdata, '0);
         end else begin
            oldest_result = pending_results.pop_front();
            if (observed_result.status !== oldest_result.status)
               report_mismatch("status", observed_result.status, oldest_result.status);
            if (observed_result.start_frame !== oldest_result.start_frame)
               report_mismatch("start_frame", observed_result.start_frame,
                               oldest_result.start_frame);
            if (observed_result.frame_used !== oldest_result.frame_used)
               report_mismatch("frame_used", observed_result.frame_used,
                               oldest_result.frame_used);
            if (observed_result.used_total !== oldest_result.used_total)
               report_mismatch("used_total", observed_result.used_total,
                               oldest_result.used_total);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_reset_state();
      send_request(ACT_COUNT, '0, '0);
      send_request(ACT_QUERY, '0, '0);
   endtask

   // Take every frame in one run, then release the map from both ends.
   task automatic test_whole_map();
      send_request(ACT_ALLOC, '0, FRAME_CAP);
      send_request(ACT_COUNT, '0, '0);
      send_request(ACT_ALLOC, '0, 13'd1);
      send_request(ACT_ALLOC, '0, '0);
      send_request(ACT_FREE, 12'd4095, LEN_ALL_ONES);
      send_request(ACT_ALLOC, '0, 13'd1);
      send_request(ACT_FREE, '0, FRAME_CAP);
   endtask

   task automatic test_run_edges();
      send_request(ACT_FORCE, 12'd100, '0);
      send_request(ACT_FREE, 12'd200, '0);
      send_request(ACT_FORCE, 12'd100, 13'd50);
      send_request(ACT_QUERY, 12'd149, '0);
      // The hole below the forced run is exactly big enough.
      send_request(ACT_ALLOC, 12'd4095, 13'd100);
      send_request(ACT_FREE, '0, 13'd150);
   endtask

   task automatic test_unknown_actions();
      for (int a = ACT_RSVD_FIRST; a <= ACT_RSVD_LAST; a++) begin
         send_request(ACT_W'(a), FRAME_W'($urandom), LEN_W'($urandom));
      end
   endtask

   task automatic test_limit_edges();
      write_limit(13'd64);
      send_request(ACT_FORCE, 12'd60, 13'd10);
      send_request(ACT_QUERY, 12'd64, '0);
      send_request(ACT_COUNT, '0, '0);
      send_request(ACT_ALLOC, '0, 13'd61);
      // With no frames managed, the used frames below 64 drop out of the count.
      write_limit('0);
      send_request(ACT_QUERY, '0, '0);
      send_request(ACT_ALLOC, '0, 13'd1);
      send_request(ACT_COUNT, '0, '0);
      write_limit(LEN_ALL_ONES);
      send_request(ACT_COUNT, '0, '0);
      send_request(ACT_QUERY, 12'd4095, '0);
   endtask

   function automatic logic [FRAME_W-1:0] pick_page(input int unsigned lim);
      int unsigned r;
      int unsigned near;
      r = $urandom_range(9);
      if (lim == 0 || r < 3) return FRAME_W'($urandom_range(NUM_FRAMES - 1));
      if (r == 3) begin
         near = lim - 1 + $urandom_range(2);
         return FRAME_W'((near > NUM_FRAMES - 1) ? NUM_FRAMES - 1 : near);
      end
      return FRAME_W'($urandom_range(lim - 1));
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3) return '0;
      if (r < 70) return LEN_W'($urandom_range(16, 1));
      if (r < 90) return LEN_W'($urandom_range(200, 17));
      if (r < 97) return LEN_W'($urandom_range(NUM_FRAMES, 201));
      return LEN_W'($urandom);
   endfunction

   task automatic test_random_traffic(input int unsigned n_items,
                                      input logic [LEN_W-1:0] limit_value);
      int unsigned      pick;
      int unsigned      lim;
      logic [ACT_W-1:0] act;
      logic [FRAME_W-1:0] page;
      logic [LEN_W-1:0] len;
      write_limit(limit_value);
      for (int unsigned k = 0; k < n_items; k++) begin
         lim  = managed_frames();
         pick = $urandom_range(99);
         page = pick_page(lim);
         len  = pick_length();
         if (pick < 32) begin
            act = ACT_ALLOC;
         end else if (pick < 46) begin
            act = ACT_FREE;
         end else if (pick < 56) begin
            act = ACT_FORCE;
         end else if (pick < 74) begin
            act = ACT_QUERY;
         end else if (pick < 86) begin
            act = ACT_COUNT;
         end else if (pick < 90) begin
            // Release everything now and then so allocations keep finding runs.
            act  = ACT_FREE;
            page = '0;
            len  = FRAME_CAP;
         end else if (pick < 96) begin
            act = ACT_FORCE;
         end else begin
            act  = ACT_W'($urandom_range(ACT_RSVD_LAST, ACT_RSVD_FIRST));
            page = FRAME_W'($urandom);
            len  = LEN_W'($urandom);
         end
         send_request(act, page, len);
         if (k % 97 == 96) wait_for_drain();
      end
   endtask

   initial begin
      logic [LEN_W-1:0] phase_limits [8];
      int unsigned      drain_cycles;
      phase_limits = '{LEN_ALL_ONES, LIMIT_RESET, 13'd300, 13'd32, 13'd1, 13'd4095,
                       LEN_W'($urandom), 13'd2048};
      foreach (free_bits[w]) free_bits[w] = ALL_FREE;
      limit_shadow = LIMIT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_whole_map();
      test_run_edges();
      test_unknown_actions();
      test_limit_edges();
      foreach (phase_limits[p]) begin
         quiet_mode = (p == 2);
         test_random_traffic(175, phase_limits[p]);
      end
      quiet_mode = 1'b0;

      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (pending_results.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (pending_results.size() != 0)
         report_mismatch("responses never returned", pending_results.size(), '0);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
